// ----- hw/rtl/epsc_pkg.sv -----
// Shared types and constants for the encoder PI speed controller.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package epsc_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KI     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 3'd4;

   // Drive modes; any other code stops the motor.
   localparam logic [1:0] MODE_FWD  = 2'd0;
   localparam logic [1:0] MODE_REV  = 2'd1;
   localparam logic [1:0] MODE_STOP = 2'd2;

   localparam logic [15:0] SPEED_BIAS  = 16'h7FFF;
   localparam logic [11:0] INTEG_MAX   = 12'd3200;
   localparam logic [6:0]  PCT_MAX     = 7'd100;
   localparam logic [15:0] PERIOD_RST  = 16'd1200;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**23.
   localparam logic [23:0] RECIP_100   = 24'd10737419;
   localparam int          RECIP_SHIFT = 30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL,
      ST_INT,
      ST_DUTY,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   // Step enables from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic calc_err;
      logic calc_mul;
      logic calc_int;
      logic calc_duty;
      logic calc_scale;
      logic calc_div;
      logic load_out;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/epsc_ctrl.sv -----
// Sequencing state machine of the encoder PI speed controller.
// Depends on epsc_pkg; drives the step enables of epsc_dpath and the stream handshakes.
`default_nettype none

module epsc_ctrl
   import epsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_INT;
         end
         ST_INT: begin
            cmd.calc_int = 1'b1;
            state_in     = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.calc_duty = 1'b1;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd.calc_div = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // The result moves into the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/epsc_dpath.sv -----
// Datapath of the encoder PI speed controller: settings, controller state and arithmetic.
// Depends on epsc_pkg; every step is enabled by a command from epsc_ctrl.
`default_nettype none

module epsc_dpath
   import epsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [15:0]           encoder_count,
   output logic signed [15:0]         measured_speed,
   output logic [6:0]                 display_speed,
   output logic [6:0]                 duty_percent,
   output logic [15:0]                compare_value,
   output logic                       forward_pin,
   output logic                       reverse_pin
);

   // Settings.
   logic [13:0] target_ff;
   logic [7:0]  kp_ff;
   logic [7:0]  ki_ff;
   logic [1:0]  mode_ff;
   logic [15:0] period_ff;

   // Controller state kept across samples.
   logic [11:0]        integral_ff, integral_in;
   logic signed [15:0] last_err_ff;

   // Per-sample working registers.
   logic [15:0]        raw_ff;
   logic signed [15:0] speed_ff, speed_in;
   logic [6:0]         disp_ff, disp_in;
   logic signed [15:0] err_ff, err_in;
   logic               fwd_ff, rev_ff, fwd_in, rev_in;
   logic signed [24:0] ki_prod_ff, ki_prod_in;
   logic signed [24:0] kp_prod_ff, kp_prod_in;
   logic [6:0]         duty_ff, duty_in;
   logic [22:0]        scaled_ff, scaled_in;
   logic [15:0]        cmp_ff, cmp_in;

   // Output register.
   logic signed [15:0] out_speed_ff;
   logic [6:0]         out_disp_ff, out_duty_ff;
   logic [15:0]        out_cmp_ff;
   logic               out_fwd_ff, out_rev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         kp_ff     <= '0;
         ki_ff     <= '0;
         mode_ff   <= MODE_STOP;
         period_ff <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET: target_ff <= csr_wdata[13:0];
            REG_KP:     kp_ff     <= csr_wdata[7:0];
            REG_KI:     ki_ff     <= csr_wdata[7:0];
            REG_MODE:   mode_ff   <= csr_wdata[1:0];
            REG_PERIOD: period_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Error step: speed, display value and the capped error.
   logic [15:0]        abs_speed;
   logic signed [17:0] twice_tgt, spd_ext, err_raw;

   always_comb begin
      speed_in  = $signed(raw_ff - SPEED_BIAS);
      abs_speed = speed_in[15] ? (16'd0 - speed_in) : speed_in;
      // Half the magnitude, truncated, equals the magnitude of the truncated half.
      disp_in   = (abs_speed[15:1] > 15'(PCT_MAX)) ? PCT_MAX : abs_speed[7:1];
      twice_tgt = $signed({3'b000, target_ff, 1'b0});
      spd_ext   = $signed({{2{speed_in[15]}}, speed_in});
      fwd_in    = 1'b0;
      rev_in    = 1'b0;
      case (mode_ff)
         MODE_FWD: begin
            fwd_in  = 1'b1;
            err_raw = twice_tgt - spd_ext;
         end
         MODE_REV: begin
            rev_in  = 1'b1;
            err_raw = twice_tgt + spd_ext;
         end
         default: begin
            err_raw = $signed({{2{last_err_ff[15]}}, last_err_ff});
         end
      endcase
      if (err_raw > 18'sd100) begin
         err_in = 16'sd100;
      end else begin
         err_in = err_raw[15:0];
      end
   end

   assign ki_prod_in = $signed({{9{err_ff[15]}}, err_ff}) * $signed({17'b0, ki_ff});
   assign kp_prod_in = $signed({{9{err_ff[15]}}, err_ff}) * $signed({17'b0, kp_ff});

   // Integral update, clamped to its range.
   logic signed [25:0] isum;

   always_comb begin
      isum = $signed({14'b0, integral_ff}) + $signed({ki_prod_ff[24], ki_prod_ff});
      if (isum[25]) begin
         integral_in = '0;
      end else if (isum > $signed({14'b0, INTEG_MAX})) begin
         integral_in = INTEG_MAX;
      end else begin
         integral_in = isum[11:0];
      end
   end

   // Duty step: proportional term plus integral, floor-shifted and clamped.
   logic signed [25:0] dsum;

   always_comb begin
      dsum = $signed({kp_prod_ff[24], kp_prod_ff}) + $signed({14'b0, integral_ff});
      if (dsum[25]) begin
         duty_in = '0;
      end else if (dsum[24:5] > 20'(PCT_MAX)) begin
         duty_in = PCT_MAX;
      end else begin
         duty_in = dsum[11:5];
      end
   end

   assign scaled_in = {16'b0, duty_ff} * {7'b0, period_ff};

   logic [46:0] recip_prod;

   assign recip_prod = {24'b0, scaled_ff} * {23'b0, RECIP_100};
   assign cmp_in     = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         last_err_ff <= '0;
      end else begin
         if (cmd.calc_err) begin
            last_err_ff <= err_in;
         end
         if (cmd.calc_int) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_ff <= encoder_count;
      end
      if (cmd.calc_err) begin
         speed_ff <= speed_in;
         disp_ff  <= disp_in;
         err_ff   <= err_in;
         fwd_ff   <= fwd_in;
         rev_ff   <= rev_in;
      end
      if (cmd.calc_mul) begin
         ki_prod_ff <= ki_prod_in;
         kp_prod_ff <= kp_prod_in;
      end
      if (cmd.calc_duty) begin
         duty_ff <= duty_in;
      end
      if (cmd.calc_scale) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.calc_div) begin
         cmp_ff <= cmp_in;
      end
      if (cmd.load_out) begin
         out_speed_ff <= speed_ff;
         out_disp_ff  <= disp_ff;
         out_duty_ff  <= duty_ff;
         out_cmp_ff   <= cmp_ff;
         out_fwd_ff   <= fwd_ff;
         out_rev_ff   <= rev_ff;
      end
   end

   assign measured_speed = out_speed_ff;
   assign display_speed  = out_disp_ff;
   assign duty_percent   = out_duty_ff;
   assign compare_value  = out_cmp_ff;
   assign forward_pin    = out_fwd_ff;
   assign reverse_pin    = out_rev_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_pi_speed_controller.sv -----
// Top level of the encoder PI speed controller.
// Depends on epsc_pkg, epsc_ctrl and epsc_dpath.
`default_nettype none

// Each accepted encoder sample yields exactly one result: the signed speed, the
// display speed, the PI duty percentage, the PWM compare value and the two direction
// pins. One sample is worked on at a time. The controller steps it through six
// datapath steps (error, the two gain products, integral clamp, duty clamp, period
// scaling and the reciprocal divide by 100) and then into the output register; a
// new sample is accepted only after the last one has moved there. A finished result
// waits in an output register, and the next sample is accepted while it waits.
// Settings are to be written through the csr port only while no sample is in
// flight; the block itself does not enforce this. Mode 3 behaves as stop.

module encoder_pi_speed_controller
   import epsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [15:0] encoder_count
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] measured_speed, [22:16] display_speed, [29:23] duty_percent,
   // [45:30] compare_value, [46] forward_pin, [47] reverse_pin
   output logic [47:0]                rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type            cmd;
   logic signed [15:0] measured_speed;
   logic [6:0]         display_speed;
   logic [6:0]         duty_percent;
   logic [15:0]        compare_value;
   logic               forward_pin;
   logic               reverse_pin;

   epsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   epsc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .encoder_count  (req_tdata),
      .measured_speed (measured_speed),
      .display_speed  (display_speed),
      .duty_percent   (duty_percent),
      .compare_value  (compare_value),
      .forward_pin    (forward_pin),
      .reverse_pin    (reverse_pin)
   );

   assign rsp_tdata = {reverse_pin, forward_pin, compare_value, duty_percent,
                       display_speed, measured_speed};

endmodule

`default_nettype wire

// ----- hw/rtl/epsc_checker.sv -----
// Port-level checks for the encoder PI speed controller, bound to its top level.
// Depends on epsc_pkg for the percentage limit.
`default_nettype none

module epsc_checker
   import epsc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // A result that is not taken stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // Only one sample is in flight, so a transfer closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a sample is in flight");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:23] <= PCT_MAX)
      else $error("duty percentage above limit");

   a_display_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:16] <= PCT_MAX)
      else $error("display speed above limit");

   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[46] && rsp_tdata[47]))
      else $error("both direction pins driven");

endmodule

bind encoder_pi_speed_controller epsc_checker u_epsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
